[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HMVN_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define HMVN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define HMVN_ASSERT(label, clk, rst_n, cond, msg)

`define HMVN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/hmvn_pkg.sv]
// ----------------------------------------------------------------------------
// hmvn_pkg
// Constants shared by the heightmap vertex normal stream.
// ----------------------------------------------------------------------------
package hmvn_pkg;

    localparam int DEFAULT_MAX_POINTS  = 256;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int GRID_POINTS_W = 9;
    localparam int GRID_STEP_W   = 15;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_POINTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UV_STEP       = 2'd3;

    localparam logic [GRID_POINTS_W-1:0] RST_GRID_POINTS = 9'd2;
    localparam logic [15:0]              RST_ORIGIN      = 16'hFF80;
    localparam logic [GRID_STEP_W-1:0]   RST_GRID_STEP   = 15'd256;
    localparam logic [15:0]              RST_UV_STEP     = 16'h8000;

    localparam int ONE_Q14 = 16384;
    localparam int ONE_Q15 = 32768;
    localparam int Y_ONE   = 256;

    localparam int M_TDATA_W  = 128;
    localparam int FRAC_SHIFT = 28;
    localparam int RAD_W      = 62;
    localparam int Q_W        = 31;
    localparam int SQ_STAGES  = 31;
    localparam int DIV_W      = 47;
    localparam int DIV_STAGES = 16;

endpackage

[rtl/heightmap_vertex_normal_stream_core.sv]
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_stream_core
// Turns a raster stream of heightmap samples into vertices with unit normals.
// ----------------------------------------------------------------------------
// The core takes one height sample per clock while its skid entry is empty,
// and gives the vertex of row r-1 while row r streams in; every sample of
// the final row gives two vertices, so there the output side holds back the
// input. Front stages form the differences and the squared length, a 31-stage
// square root unit and a 16-stage divider unit (three quotients side by side)
// build the normal, and two stages add position and texture coordinates.
// Two line stores of MAX_POINTS entries, each with one read and one write
// port, hold the last two rows. An output register with one skid entry lets
// the input keep going while a vertex waits to be taken.
`include "assert_macros.svh"

module heightmap_vertex_normal_stream_core #(
    parameter int MAX_POINTS  = hmvn_pkg::DEFAULT_MAX_POINTS,
    parameter int SAMPLE_BITS = hmvn_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [hmvn_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [hmvn_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // height
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y, normal_z
    output logic [hmvn_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // grid_end
    output logic                                m_tuser
);

    import hmvn_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int N_W   = IDX_W + 1;
    localparam int CW    = (N_W > GRID_POINTS_W) ? N_W : GRID_POINTS_W;
    localparam int SW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 17;
    localparam int PX_W  = IDX_W + GRID_STEP_W;
    localparam int TX_W  = IDX_W + 16;
    localparam int SUM_W = PX_W + 2;
    localparam logic [15:0] ONE14 = 16'(ONE_Q14);
    localparam logic [TX_W-1:0] ONE15 = TX_W'(ONE_Q15);

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             has_a;
        logic             has_b;
        logic             b_end;
        logic [15:0]      hp;
        logic [15:0]      h;
    } meta_t;

    typedef struct packed {
        meta_t            meta;
        logic [15:0]      ax;
        logic [15:0]      az;
        logic             sx;
        logic             sz;
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } sq_t;

    typedef struct packed {
        meta_t            meta;
        logic             sx;
        logic             sz;
        logic [Q_W-1:0]   q;
        logic [DIV_W-1:0] rx;
        logic [DIV_W-1:0] ry;
        logic [DIV_W-1:0] rz;
        logic [15:0]      qx;
        logic [15:0]      qy;
        logic [15:0]      qz;
    } dv_t;

    typedef struct packed {
        meta_t           meta;
        logic [15:0]     nx;
        logic [14:0]     ny;
        logic [15:0]     nz;
        logic [PX_W-1:0] px;
        logic [PX_W-1:0] pza;
        logic [PX_W-1:0] pzb;
        logic [TX_W-1:0] tu;
        logic [TX_W-1:0] tva;
        logic [TX_W-1:0] tvb;
    } p1_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_za;
        logic [15:0] pos_zb;
        logic [15:0] tex_u;
        logic [15:0] tex_va;
        logic [15:0] tex_vb;
        logic [15:0] hp;
        logic [15:0] h;
        logic [15:0] nx;
        logic [14:0] ny;
        logic [15:0] nz;
        logic        has_a;
        logic        has_b;
        logic        b_end;
    } res_t;

    function automatic sq_t sq_step(input sq_t src, input int k);
        sq_t              res;
        logic [RAD_W-1:0] bitv;
        logic [RAD_W-1:0] trial;
        res   = src;
        bitv  = RAD_W'(1) << (2 * (SQ_STAGES - 1 - k));
        trial = src.root + bitv;
        if (src.rem >= trial) begin
            res.rem  = src.rem - trial;
            res.root = (src.root >> 1) + bitv;
        end else begin
            res.root = src.root >> 1;
        end
        return res;
    endfunction

    function automatic dv_t div_step(input dv_t src, input int b);
        dv_t              res;
        logic [DIV_W-1:0] d;
        res = src;
        d   = DIV_W'(src.q) << b;
        if (src.rx >= d) begin
            res.rx    = src.rx - d;
            res.qx[b] = 1'b1;
        end
        if (src.ry >= d) begin
            res.ry    = src.ry - d;
            res.qy[b] = 1'b1;
        end
        if (src.rz >= d) begin
            res.rz    = src.rz - d;
            res.qz[b] = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [15:0] place(input logic [15:0] org, input logic [PX_W-1:0] prod);
        logic signed [SUM_W-1:0] sum;
        logic [15:0]             res;
        sum = SUM_W'($signed(org)) + $signed({2'b00, prod});
        if (sum > $signed(SUM_W'(32767))) begin
            res = 16'h7FFF;
        end else if (sum < $signed(-SUM_W'(32768))) begin
            res = 16'h8000;
        end else begin
            res = sum[15:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] tex(input logic [TX_W-1:0] prod);
        return (prod > ONE15) ? ONE15[15:0] : prod[15:0];
    endfunction

    logic [GRID_POINTS_W-1:0] gp_reg;
    logic [15:0]              origin_reg;
    logic [GRID_STEP_W-1:0]   step_reg;
    logic [15:0]              uv_reg;
    logic [IDX_W-1:0]         col_cnt_reg;
    logic [IDX_W-1:0]         row_cnt_reg;

    logic [CW-1:0]            gp_ext;
    logic [N_W-1:0]           n_used;
    logic [IDX_W-1:0]         last_idx;
    logic                     last_col;
    logic                     last_row;
    logic                     interior;
    logic [IDX_W-1:0]         rd_addr;
    logic                     en;
    logic                     accept;

    logic [SAMPLE_BITS-1:0]   samp_raw;
    logic signed [SW-1:0]     samp_ext;
    logic signed [15:0]       samp;

    logic signed [15:0]       prev_mem [MAX_POINTS];
    logic signed [15:0]       older_mem [MAX_POINTS];
    logic signed [15:0]       pf_prev_reg;
    logic signed [15:0]       pf_older_reg;
    logic signed [15:0]       left_reg;

    meta_t                    meta_next;
    meta_t                    meta0_reg;
    logic signed [15:0]       left0_reg;
    logic signed [15:0]       down0_reg;
    logic                     int0_reg;
    logic                     v0_reg;

    meta_t                    meta1_reg;
    logic signed [16:0]       dx1_reg;
    logic signed [16:0]       dz1_reg;
    logic                     v1_reg;

    meta_t                    meta2_reg;
    logic [31:0]              sqx2_reg;
    logic [31:0]              sqz2_reg;
    logic [15:0]              ax2_reg;
    logic [15:0]              az2_reg;
    logic                     sx2_reg;
    logic                     sz2_reg;
    logic                     v2_reg;
    logic [15:0]              ax1;
    logic [15:0]              az1;

    sq_t                      sq_head;
    logic [33:0]              rad3;
    sq_t                      sq_src [SQ_STAGES];
    sq_t                      sq_reg [SQ_STAGES];
    logic [SQ_STAGES-1:0]     sq_v_reg;
    logic [Q_W-1:0]           q_fin;

    dv_t                      dv_head_reg;
    logic                     dv_head_v_reg;
    dv_t                      dv_src [DIV_STAGES];
    dv_t                      dv_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]    dv_v_reg;
    dv_t                      dv_last;

    p1_t                      p1_next;
    p1_t                      p1_reg;
    logic                     p1_v_reg;
    logic [15:0]              ux;
    logic [15:0]              uy;
    logic [15:0]              uz;
    logic [IDX_W-1:0]         row_a;

    res_t                     p2_next;
    res_t                     p2_reg;
    logic                     p2_v_reg;

    res_t                     out_reg;
    res_t                     skid_reg;
    logic                     out_v_reg;
    logic                     skid_v_reg;
    logic                     out_phase_reg;
    logic                     incoming;
    logic                     out_final;
    logic                     out_pop;
    logic                     out_free;
    logic                     show_a;

    // Configuration and grid position.
    always_comb begin
        gp_ext = CW'(gp_reg);
        if (gp_ext < CW'(2)) begin
            n_used = N_W'(2);
        end else if (gp_ext > CW'(MAX_POINTS)) begin
            n_used = N_W'(MAX_POINTS);
        end else begin
            n_used = N_W'(gp_ext);
        end
        last_idx = IDX_W'(n_used - N_W'(1));
        last_col = (col_cnt_reg == last_idx);
        last_row = (row_cnt_reg == last_idx);
        interior = (row_cnt_reg >= IDX_W'(2)) && (col_cnt_reg != '0) && !last_col;
        rd_addr  = last_col ? '0 : IDX_W'(col_cnt_reg + 1'b1);
    end

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_comb begin
        samp_raw = s_tdata[SAMPLE_BITS-1:0];
        samp_ext = SW'($signed(samp_raw));
        if (samp_ext > $signed(SW'(32767))) begin
            samp = 16'sh7FFF;
        end else if (samp_ext < $signed(-SW'(32768))) begin
            samp = 16'sh8000;
        end else begin
            samp = samp_ext[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gp_reg      <= RST_GRID_POINTS;
            origin_reg  <= RST_ORIGIN;
            step_reg    <= RST_GRID_STEP;
            uv_reg      <= RST_UV_STEP;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_GRID_POINTS: begin
                    gp_reg      <= cfg_wr_data[GRID_POINTS_W-1:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                end
                REG_ORIGIN_OFFSET: begin
                    origin_reg <= cfg_wr_data;
                end
                REG_GRID_STEP: begin
                    step_reg <= cfg_wr_data[GRID_STEP_W-1:0];
                end
                REG_UV_STEP: begin
                    uv_reg <= cfg_wr_data;
                end
            endcase
        end else if (accept) begin
            if (last_col) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : IDX_W'(row_cnt_reg + 1'b1);
            end else begin
                col_cnt_reg <= IDX_W'(col_cnt_reg + 1'b1);
            end
        end
    end

    // Line stores; the entries for the next column are fetched ahead.
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_mem[col_cnt_reg]  <= samp;
            older_mem[col_cnt_reg] <= pf_prev_reg;
            pf_prev_reg            <= prev_mem[rd_addr];
            pf_older_reg           <= older_mem[rd_addr];
            left_reg               <= pf_prev_reg;
        end
    end

    always_comb begin
        meta_next.col   = col_cnt_reg;
        meta_next.row   = row_cnt_reg;
        meta_next.has_a = (row_cnt_reg != '0);
        meta_next.has_b = last_row;
        meta_next.b_end = last_row && last_col;
        meta_next.hp    = pf_prev_reg;
        meta_next.h     = samp;
    end

    // Front stages: differences, squares, squared length.
    always_comb begin
        ax1 = dx1_reg[16] ? 16'(-dx1_reg) : 16'(dx1_reg);
        az1 = dz1_reg[16] ? 16'(-dz1_reg) : 16'(dz1_reg);
        rad3 = 34'(sqx2_reg) + 34'(sqz2_reg) + 34'(Y_ONE * Y_ONE);
        sq_head.meta = meta2_reg;
        sq_head.ax   = ax2_reg;
        sq_head.az   = az2_reg;
        sq_head.sx   = sx2_reg;
        sq_head.sz   = sz2_reg;
        sq_head.rem  = {rad3, {FRAC_SHIFT{1'b0}}};
        sq_head.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta0_reg <= meta_next;
            left0_reg <= left_reg;
            down0_reg <= pf_older_reg;
            int0_reg  <= interior;
            meta1_reg <= meta0_reg;
            dx1_reg   <= int0_reg ? (17'(left0_reg) - 17'(pf_prev_reg)) : '0;
            dz1_reg   <= int0_reg ? (17'(down0_reg) - 17'($signed(meta0_reg.h))) : '0;
            meta2_reg <= meta1_reg;
            sqx2_reg  <= ax1 * ax1;
            sqz2_reg  <= az1 * az1;
            ax2_reg   <= ax1;
            az2_reg   <= az1;
            sx2_reg   <= dx1_reg[16];
            sz2_reg   <= dz1_reg[16];
        end
    end

    // Square root unit, one result bit per stage.
    always_comb begin
        sq_src[0] = sq_head;
        for (int k = 1; k < SQ_STAGES; k++) begin
            sq_src[k] = sq_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                sq_reg[k] <= sq_step(sq_src[k], k);
            end
        end
    end

    assign q_fin = sq_reg[SQ_STAGES-1].root[Q_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_head_reg.meta <= sq_reg[SQ_STAGES-1].meta;
            dv_head_reg.sx   <= sq_reg[SQ_STAGES-1].sx;
            dv_head_reg.sz   <= sq_reg[SQ_STAGES-1].sz;
            dv_head_reg.q    <= q_fin;
            dv_head_reg.rx   <= (DIV_W'(sq_reg[SQ_STAGES-1].ax) << FRAC_SHIFT)
                                + DIV_W'(q_fin >> 1);
            dv_head_reg.ry   <= (DIV_W'(Y_ONE) << FRAC_SHIFT) + DIV_W'(q_fin >> 1);
            dv_head_reg.rz   <= (DIV_W'(sq_reg[SQ_STAGES-1].az) << FRAC_SHIFT)
                                + DIV_W'(q_fin >> 1);
            dv_head_reg.qx   <= '0;
            dv_head_reg.qy   <= '0;
            dv_head_reg.qz   <= '0;
        end
    end

    // Divider unit, one quotient bit per stage for all three components.
    always_comb begin
        dv_src[0] = dv_head_reg;
        for (int j = 1; j < DIV_STAGES; j++) begin
            dv_src[j] = dv_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                dv_reg[j] <= div_step(dv_src[j], DIV_STAGES - 1 - j);
            end
        end
    end

    assign dv_last = dv_reg[DIV_STAGES-1];

    // Output stages: normal limits and signs, position and texture products.
    always_comb begin
        ux    = (dv_last.qx > ONE14) ? ONE14 : dv_last.qx;
        uy    = (dv_last.qy > ONE14) ? ONE14 : dv_last.qy;
        uz    = (dv_last.qz > ONE14) ? ONE14 : dv_last.qz;
        row_a = IDX_W'(dv_last.meta.row - 1'b1);
        p1_next.meta = dv_last.meta;
        p1_next.nx   = dv_last.sx ? 16'(-ux) : ux;
        p1_next.ny   = uy[14:0];
        p1_next.nz   = dv_last.sz ? 16'(-uz) : uz;
        p1_next.px   = PX_W'(dv_last.meta.col) * PX_W'(step_reg);
        p1_next.pza  = PX_W'(row_a) * PX_W'(step_reg);
        p1_next.pzb  = PX_W'(dv_last.meta.row) * PX_W'(step_reg);
        p1_next.tu   = TX_W'(dv_last.meta.col) * TX_W'(uv_reg);
        p1_next.tva  = TX_W'(row_a) * TX_W'(uv_reg);
        p1_next.tvb  = TX_W'(dv_last.meta.row) * TX_W'(uv_reg);
    end

    always_comb begin
        p2_next.pos_x  = place(origin_reg, p1_reg.px);
        p2_next.pos_za = place(origin_reg, p1_reg.pza);
        p2_next.pos_zb = place(origin_reg, p1_reg.pzb);
        p2_next.tex_u  = tex(p1_reg.tu);
        p2_next.tex_va = tex(p1_reg.tva);
        p2_next.tex_vb = tex(p1_reg.tvb);
        p2_next.hp     = p1_reg.meta.hp;
        p2_next.h      = p1_reg.meta.h;
        p2_next.nx     = p1_reg.nx;
        p2_next.ny     = p1_reg.ny;
        p2_next.nz     = p1_reg.nz;
        p2_next.has_a  = p1_reg.meta.has_a;
        p2_next.has_b  = p1_reg.meta.has_b;
        p2_next.b_end  = p1_reg.meta.b_end;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sq_v_reg      <= '0;
            dv_head_v_reg <= 1'b0;
            dv_v_reg      <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
        end else if (en) begin
            v0_reg        <= accept;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            sq_v_reg      <= {sq_v_reg[SQ_STAGES-2:0], v2_reg};
            dv_head_v_reg <= sq_v_reg[SQ_STAGES-1];
            dv_v_reg      <= {dv_v_reg[DIV_STAGES-2:0], dv_head_v_reg};
            p1_v_reg      <= dv_v_reg[DIV_STAGES-1];
            p2_v_reg      <= p1_v_reg;
        end
    end

    // Output register with one skid entry. A final-row entry gives two
    // transactions: the vertex of the row before, then its own vertex.
    assign incoming  = en && p2_v_reg && (p2_reg.has_a || p2_reg.has_b);
    assign out_final = !(out_reg.has_a && out_reg.has_b) || out_phase_reg;
    assign out_pop   = out_v_reg && m_tready && out_final;
    assign out_free  = !out_v_reg || out_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg     <= 1'b0;
            skid_v_reg    <= 1'b0;
            out_phase_reg <= 1'b0;
        end else if (out_free) begin
            out_phase_reg <= 1'b0;
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= incoming;
            end
        end else begin
            if (incoming) begin
                skid_v_reg <= 1'b1;
            end
            if (m_tready) begin
                out_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_v_reg) begin
                out_reg <= skid_reg;
            end else if (incoming) begin
                out_reg <= p2_reg;
            end
        end else if (incoming) begin
            skid_reg <= p2_reg;
        end
    end

    assign show_a   = out_reg.has_a && !out_phase_reg;
    assign m_tvalid = out_v_reg;
    assign m_tlast  = show_a ? !out_reg.has_b : 1'b1;
    assign m_tuser  = show_a ? 1'b0 : out_reg.b_end;
    assign m_tdata  = show_a
        ? {1'b0, out_reg.nz, out_reg.ny, out_reg.nx, out_reg.tex_va, out_reg.tex_u,
           out_reg.pos_za, out_reg.hp, out_reg.pos_x}
        : {1'b0, 16'h0000, ONE14[14:0], 16'h0000, out_reg.tex_vb, out_reg.tex_u,
           out_reg.pos_zb, out_reg.h, out_reg.pos_x};

    `HMVN_ASSERT_IMP(a_skid_needs_out, aclk, aresetn, skid_v_reg, out_v_reg, "skid entry held while output register is empty")
    `HMVN_ASSERT_IMP(a_phase_two_results, aclk, aresetn, out_phase_reg, out_v_reg && out_reg.has_a && out_reg.has_b, "second result phase on an entry without two results")
    `HMVN_ASSERT_IMP(a_out_has_result, aclk, aresetn, out_v_reg, out_reg.has_a || out_reg.has_b, "output entry carries no result")
    `HMVN_ASSERT(a_col_in_grid, aclk, aresetn, N_W'(col_cnt_reg) < n_used, "column counter beyond grid size")

endmodule
